// ===== sv/csx_pkg.sv =====
// Shared types and constants for the subarray XOR counting unit.
// Depends on nothing; csx_out_fifo and count_subarrays_with_xor_unit refer to it by scoped names.
package csx_pkg;

	// Fixed field widths of the item and result beats
	localparam int DATA_BITS  = 16;
	localparam int TOTAL_BITS = 31;

	// Epoch tag stored with each histogram word; a wrap forces a clearing sweep
	localparam int EPOCH_BITS = 8;

	// Result buffer depth: covers the beat in flight plus two waiting beats
	localparam int OUT_DEPTH  = 3;
	localparam int LEVEL_BITS = $clog2(OUT_DEPTH + 1);

	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	typedef struct packed {
		logic [DATA_BITS-1:0] element;
		logic                 last_element;
	} item_t;

	typedef struct packed {
		logic [TOTAL_BITS-1:0] subarray_count;
		logic                  array_done;
	} result_t;

endpackage

// ===== sv/csx_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
// Depends on nothing; read during write at the same address returns old data.
module csx_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read two, data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== sv/csx_out_fifo.sv =====
// Small result buffer that decouples the histogram pipeline from result stall.
// Depends on csx_pkg for the result beat type and the buffer depth.
module csx_out_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  csx_pkg::result_t                push_data,
	output logic                            result_valid,
	input  logic                            result_stall,
	output csx_pkg::result_t                result,
	output logic [csx_pkg::LEVEL_BITS-1:0]  level
);

	localparam int PTR_BITS = $clog2(csx_pkg::OUT_DEPTH);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(csx_pkg::OUT_DEPTH - 1);

	csx_pkg::result_t                 mem_q [csx_pkg::OUT_DEPTH];
	logic [PTR_BITS-1:0]              wr_ptr_q;
	logic [PTR_BITS-1:0]              rd_ptr_q;
	logic [csx_pkg::LEVEL_BITS-1:0]   level_q;
	logic                             pop;

	assign result_valid = (level_q != '0);
	assign result       = mem_q[rd_ptr_q];
	assign pop          = result_valid && !result_stall;
	assign level        = level_q;

	// Store pushed beats
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/count_subarrays_with_xor_unit.sv =====
// Subarray XOR counter: running prefix XOR with a histogram in one RAM.
// A result beat passes the stage-1 register and the result buffer before it is offered.
// Throughput: one item per cycle while item_stall is low; each histogram
// read-modify-write has its last write forwarded to the item right behind it.
// Reset and every 2^EPOCH_BITS-th array end start a sweep over all 2^VALUE_BITS
// addresses that rewrites the histogram; item_stall is high during the sweep.
module count_subarrays_with_xor_unit #(
	parameter int VALUE_BITS = 16,
	parameter int MAX_LENGTH = 65535
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  csx_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output csx_pkg::result_t              result,
	input  logic                          target_valid,
	output logic                          target_ready,
	input  logic [csx_pkg::DATA_BITS-1:0] target_xor
);

	localparam int DEPTH      = 1 << VALUE_BITS;
	localparam int COUNT_BITS = $clog2(MAX_LENGTH + 2);
	localparam int WORD_BITS  = csx_pkg::EPOCH_BITS + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [csx_pkg::EPOCH_BITS-1:0] EPOCH_MAX = {csx_pkg::EPOCH_BITS{1'b1}};
	localparam logic [VALUE_BITS-1:0] ADDR_LAST = {VALUE_BITS{1'b1}};

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	state_t                            state_q;
	logic [VALUE_BITS-1:0]             clr_addr_q;
	logic [csx_pkg::EPOCH_BITS-1:0]    epoch_q;
	logic [VALUE_BITS-1:0]             prefix_q;
	logic [csx_pkg::DATA_BITS-1:0]     target_q;
	logic [csx_pkg::TOTAL_BITS-1:0]    total_q;

	logic                              s1_valid_q;
	logic [VALUE_BITS-1:0]             pfx_s1;
	logic [VALUE_BITS-1:0]             wanted_s1;
	logic                              last_s1;
	logic [csx_pkg::EPOCH_BITS-1:0]    epoch_s1;

	logic                              fwd_valid_q;
	logic [VALUE_BITS-1:0]             fwd_addr_q;
	logic [WORD_BITS-1:0]              fwd_word_q;

	logic                              accept;
	logic                              clearing;
	logic [VALUE_BITS-1:0]             pfx_next;
	logic [VALUE_BITS-1:0]             wanted;
	logic [WORD_BITS-1:0]              rd_wanted;
	logic [WORD_BITS-1:0]              rd_pfx;
	logic [WORD_BITS-1:0]              word_w;
	logic [WORD_BITS-1:0]              word_p;
	logic [COUNT_BITS-1:0]             cnt_w;
	logic [COUNT_BITS-1:0]             cnt_p;
	logic [COUNT_BITS-1:0]             cnt_p_inc;
	logic [csx_pkg::TOTAL_BITS:0]      sum;
	logic [csx_pkg::TOTAL_BITS-1:0]    total_new;
	logic                              we;
	logic [VALUE_BITS-1:0]             waddr;
	logic [WORD_BITS-1:0]              wdata;
	logic [WORD_BITS-1:0]              upd_word;
	csx_pkg::result_t                  push_data;
	logic [csx_pkg::LEVEL_BITS-1:0]    level;
	logic [csx_pkg::LEVEL_BITS:0]      occupancy;

	// Handshakes
	assign clearing     = (state_q == ST_CLEAR);
	assign occupancy    = {1'b0, level} + (csx_pkg::LEVEL_BITS + 1)'(s1_valid_q);
	assign item_stall   = clearing ||
		(occupancy >= (csx_pkg::LEVEL_BITS + 1)'(csx_pkg::OUT_DEPTH));
	assign accept       = item_valid && !item_stall;
	assign target_ready = 1'b1;

	// Prefix XOR and the lookup key for the target
	assign pfx_next = prefix_q ^ VALUE_BITS'(item.element);
	assign wanted   = pfx_next ^ VALUE_BITS'(target_q);

	// Target register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_valid && target_ready) begin
			target_q <= target_xor;
		end
	end

	// Sequencer: clearing sweep, epoch and prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			epoch_q    <= '0;
			prefix_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_LAST) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (accept) begin
						prefix_q <= item.last_element ? '0 : pfx_next;
						if (item.last_element) begin
							if (epoch_q == EPOCH_MAX) begin
								epoch_q    <= '0;
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end else begin
								epoch_q <= epoch_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pfx_s1    <= pfx_next;
			wanted_s1 <= wanted;
			last_s1   <= item.last_element;
			epoch_s1  <= epoch_q;
		end
	end

	// Stage 1 valid and the running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			total_q    <= '0;
		end else begin
			s1_valid_q <= accept;
			if (s1_valid_q) begin
				total_q <= last_s1 ? '0 : total_new;
			end
		end
	end

	// Histogram memory: {epoch tag, count} per prefix value
	csx_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_hist (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (wanted),
		.rdata_a (rd_wanted),
		.raddr_b (pfx_next),
		.rdata_b (rd_pfx)
	);

	// Forward the write that landed alongside this item's read
	assign word_w = (fwd_valid_q && fwd_addr_q == wanted_s1) ? fwd_word_q : rd_wanted;
	assign word_p = (fwd_valid_q && fwd_addr_q == pfx_s1) ? fwd_word_q : rd_pfx;

	// Words from an older epoch read as the start value
	always_comb begin
		if (word_w[WORD_BITS-1 -: csx_pkg::EPOCH_BITS] == epoch_s1) begin
			cnt_w = word_w[COUNT_BITS-1:0];
		end else begin
			cnt_w = COUNT_BITS'(wanted_s1 == '0);
		end
		if (word_p[WORD_BITS-1 -: csx_pkg::EPOCH_BITS] == epoch_s1) begin
			cnt_p = word_p[COUNT_BITS-1:0];
		end else begin
			cnt_p = COUNT_BITS'(pfx_s1 == '0);
		end
	end

	// Saturating increment and accumulate
	assign cnt_p_inc = (cnt_p == COUNT_MAX) ? cnt_p : cnt_p + 1'b1;
	assign upd_word  = {epoch_s1, cnt_p_inc};
	assign sum       = {1'b0, total_q} + (csx_pkg::TOTAL_BITS + 1)'(cnt_w);
	assign total_new = sum[csx_pkg::TOTAL_BITS] ? csx_pkg::TOTAL_MAX
		: sum[csx_pkg::TOTAL_BITS-1:0];

	// Write port: the sweep wins, the update write is dropped during it
	always_comb begin
		if (clearing) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = {{csx_pkg::EPOCH_BITS{1'b0}}, COUNT_BITS'(clr_addr_q == '0)};
		end else begin
			we    = s1_valid_q;
			waddr = pfx_s1;
			wdata = upd_word;
		end
	end

	// Register the last update for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= s1_valid_q && !clearing;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= pfx_s1;
		fwd_word_q <= upd_word;
	end

	// Result buffer
	assign push_data.subarray_count = total_new;
	assign push_data.array_done     = last_s1;

	csx_out_fifo u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (s1_valid_q),
		.push_data    (push_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.level        (level)
	);

	// No item is taken during the clearing sweep
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !accept)
		else $error("item accepted during histogram sweep");

	// The result buffer never overflows
	a_buffer_room: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= (csx_pkg::LEVEL_BITS + 1)'(csx_pkg::OUT_DEPTH))
		else $error("result buffer overflow");

	// Epoch wrap at an array end starts a sweep
	a_wrap_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.last_element && epoch_q == EPOCH_MAX) |=> clearing)
		else $error("epoch wrapped without a sweep");

endmodule
